### design/twts_pkg.sv
// ----------------------------------------------------------------------------
// twts_pkg
// Shared codes and controller/datapath interface types for the timing wheel
// task scheduler.
// ----------------------------------------------------------------------------
package twts_pkg;

	localparam logic [1:0] MODE_TICK = 2'd0;
	localparam logic [1:0] MODE_ADD  = 2'd1;
	localparam logic [1:0] MODE_REM  = 2'd2;

	localparam logic [1:0] KIND_ACC  = 2'd0;
	localparam logic [1:0] KIND_REJ  = 2'd1;
	localparam logic [1:0] KIND_FIRE = 2'd2;

	localparam logic [1:0] PLACE_IDLE = 2'd0;
	localparam logic [1:0] PLACE_SLOT = 2'd1;
	localparam logic [1:0] PLACE_OVF  = 2'd2;

	localparam int MAX_OUT = 16;
	localparam int ECNT_W  = 5;

	typedef logic [4:0] op_t;

	localparam op_t OP_CLR  = 5'd0;
	localparam op_t OP_IDLE = 5'd1;
	localparam op_t OP_DEC  = 5'd2;
	localparam op_t OP_TICK = 5'd3;
	localparam op_t OP_HRD  = 5'd4;
	localparam op_t OP_HGOT = 5'd5;
	localparam op_t OP_SHRD = 5'd6;
	localparam op_t OP_WRD  = 5'd7;
	localparam op_t OP_WDO  = 5'd8;
	localparam op_t OP_OEV  = 5'd9;
	localparam op_t OP_NX   = 5'd10;
	localparam op_t OP_ADD  = 5'd11;
	localparam op_t OP_RCHK = 5'd12;
	localparam op_t OP_PRD  = 5'd13;
	localparam op_t OP_PUNL = 5'd14;
	localparam op_t OP_TRD  = 5'd15;
	localparam op_t OP_APP1 = 5'd16;
	localparam op_t OP_APP2 = 5'd17;
	localparam op_t OP_EMIT = 5'd18;
	localparam op_t OP_FIN  = 5'd19;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       bad;
		logic       ovf;
		logic       head_nil;
		logic       nxt_nil;
		logic       left_zero;
		logic       left_small;
		logic       emit_go;
		logic       fin_go;
		logic       clr_last;
		logic       rem_ok;
	} sts_t;

endpackage

### design/timing_wheel_task_scheduler_unit.sv
// ----------------------------------------------------------------------------
// timing_wheel_task_scheduler_unit
// Periodic task scheduler on a hashed timing wheel with an overflow list.
// ----------------------------------------------------------------------------
// An add, a remove and a rejected request each give a single result, which
// appears as the item ends.
// A tick walks the slot list, and on a wrap to position zero the overflow
// list as well, emitting the tasks that fire; result stalls hold it.
// One item is in work at a time. After reset the slot lists are cleared;
// no item is accepted during that pass.
module timing_wheel_task_scheduler_unit #(
	parameter int WHEEL_SLOTS = 256,
	parameter int TASKS       = 16,
	parameter int PERIOD_BITS = 24
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // mode[1:0], task_id[5:2], period[29:6], delay[53:30]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // kind[1:0], task_id[5:2] (the fired task on a tick)
	output logic        m_tlast
);

	twts_pkg::cmd_t cmd;
	twts_pkg::sts_t sts;

	twts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	twts_dp #(
		.W     (WHEEL_SLOTS),
		.TASKS (TASKS),
		.PB    (PERIOD_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

### design/twts_ctrl.sv
// ----------------------------------------------------------------------------
// twts_ctrl
// Sequencer: walks the wheel and overflow lists, runs list placement and
// result delivery as shared sub-sequences.
// ----------------------------------------------------------------------------
module twts_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	input  twts_pkg::sts_t  sts,
	output twts_pkg::cmd_t  cmd
);

	localparam logic [4:0] S_CLR  = 5'd0;
	localparam logic [4:0] S_IDLE = 5'd1;
	localparam logic [4:0] S_DEC  = 5'd2;
	localparam logic [4:0] S_TICK = 5'd3;
	localparam logic [4:0] S_HRD  = 5'd4;
	localparam logic [4:0] S_HGOT = 5'd5;
	localparam logic [4:0] S_SHRD = 5'd6;
	localparam logic [4:0] S_WRD  = 5'd7;
	localparam logic [4:0] S_WDO  = 5'd8;
	localparam logic [4:0] S_OEV  = 5'd9;
	localparam logic [4:0] S_NX   = 5'd10;
	localparam logic [4:0] S_ADD  = 5'd11;
	localparam logic [4:0] S_RCHK = 5'd12;
	localparam logic [4:0] S_PRD  = 5'd13;
	localparam logic [4:0] S_PUNL = 5'd14;
	localparam logic [4:0] S_TRD  = 5'd15;
	localparam logic [4:0] S_APP1 = 5'd16;
	localparam logic [4:0] S_APP2 = 5'd17;
	localparam logic [4:0] S_EM   = 5'd18;
	localparam logic [4:0] S_FIN  = 5'd19;

	logic [4:0] st_q, st_d;
	logic [4:0] eret_q, eret_d;
	logic [4:0] pret_q, pret_d;

	assign s_tready = (st_q == S_IDLE);

	always_comb begin
		st_d   = st_q;
		eret_d = eret_q;
		pret_d = pret_q;
		case (st_q)
			S_CLR: begin
				if (sts.clr_last) st_d = S_IDLE;
			end
			S_IDLE: begin
				if (s_tvalid) st_d = S_DEC;
			end
			S_DEC: begin
				case (sts.mode)
					twts_pkg::MODE_TICK: st_d = S_TICK;
					twts_pkg::MODE_ADD: begin
						if (sts.bad) begin
							st_d   = S_EM;
							eret_d = S_FIN;
						end else begin
							st_d = S_ADD;
						end
					end
					twts_pkg::MODE_REM: st_d = S_RCHK;
					default: begin
						st_d   = S_EM;
						eret_d = S_FIN;
					end
				endcase
			end
			S_TICK: st_d = S_HRD;
			S_HRD:  st_d = S_HGOT;
			S_HGOT: begin
				if (!sts.head_nil) st_d = S_WRD;
				else if (sts.ovf) st_d = S_SHRD;
				else st_d = S_FIN;
			end
			S_SHRD: st_d = S_HGOT;
			S_WRD:  st_d = S_WDO;
			S_WDO: begin
				if (sts.ovf) begin
					st_d = S_OEV;
				end else begin
					st_d   = S_EM;
					eret_d = S_PRD;
					pret_d = S_NX;
				end
			end
			S_OEV: begin
				if (sts.left_zero) begin
					st_d   = S_EM;
					eret_d = S_NX;
				end else if (sts.left_small) begin
					st_d   = S_PRD;
					pret_d = S_NX;
				end else begin
					st_d = S_NX;
				end
			end
			S_NX: begin
				if (!sts.nxt_nil) st_d = S_WRD;
				else if (sts.ovf) st_d = S_SHRD;
				else st_d = S_FIN;
			end
			S_ADD: begin
				st_d   = S_PRD;
				pret_d = S_EM;
				eret_d = S_FIN;
			end
			S_RCHK: begin
				eret_d = S_FIN;
				if (sts.rem_ok) begin
					st_d   = S_PRD;
					pret_d = S_EM;
				end else begin
					st_d = S_EM;
				end
			end
			S_PRD: st_d = S_PUNL;
			S_PUNL: begin
				if (sts.mode == twts_pkg::MODE_REM) st_d = pret_q;
				else st_d = S_TRD;
			end
			S_TRD:  st_d = S_APP1;
			S_APP1: st_d = S_APP2;
			S_APP2: st_d = pret_q;
			S_EM: begin
				if (sts.emit_go) st_d = eret_q;
			end
			S_FIN: begin
				if (sts.fin_go) st_d = S_IDLE;
			end
			default: st_d = S_IDLE;
		endcase
	end

	always_comb begin
		case (st_q)
			S_CLR:   cmd.op = twts_pkg::OP_CLR;
			S_IDLE:  cmd.op = twts_pkg::OP_IDLE;
			S_DEC:   cmd.op = twts_pkg::OP_DEC;
			S_TICK:  cmd.op = twts_pkg::OP_TICK;
			S_HRD:   cmd.op = twts_pkg::OP_HRD;
			S_HGOT:  cmd.op = twts_pkg::OP_HGOT;
			S_SHRD:  cmd.op = twts_pkg::OP_SHRD;
			S_WRD:   cmd.op = twts_pkg::OP_WRD;
			S_WDO:   cmd.op = twts_pkg::OP_WDO;
			S_OEV:   cmd.op = twts_pkg::OP_OEV;
			S_NX:    cmd.op = twts_pkg::OP_NX;
			S_ADD:   cmd.op = twts_pkg::OP_ADD;
			S_RCHK:  cmd.op = twts_pkg::OP_RCHK;
			S_PRD:   cmd.op = twts_pkg::OP_PRD;
			S_PUNL:  cmd.op = twts_pkg::OP_PUNL;
			S_TRD:   cmd.op = twts_pkg::OP_TRD;
			S_APP1:  cmd.op = twts_pkg::OP_APP1;
			S_APP2:  cmd.op = twts_pkg::OP_APP2;
			S_EM:    cmd.op = twts_pkg::OP_EMIT;
			S_FIN:   cmd.op = twts_pkg::OP_FIN;
			default: cmd.op = twts_pkg::OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_CLR;
			eret_q <= S_FIN;
			pret_q <= S_FIN;
		end else begin
			st_q   <= st_d;
			eret_q <= eret_d;
			pret_q <= pret_d;
		end
	end

endmodule

### design/twts_dp.sv
// ----------------------------------------------------------------------------
// twts_dp
// Datapath: list memories, task memories, walk registers, result buffer and
// output register.
// ----------------------------------------------------------------------------
module twts_dp #(
	parameter int W     = 256,
	parameter int TASKS = 16,
	parameter int PB    = 24
) (
	input  logic            clk,
	input  logic            arst_n,
	input  twts_pkg::cmd_t  cmd,
	output twts_pkg::sts_t  sts,
	input  logic [55:0]     s_tdata,
	output logic            m_tvalid,
	input  logic            m_tready,
	output logic [7:0]      m_tdata,
	output logic            m_tlast
);

	localparam int SW  = $clog2(W);
	localparam int LI  = SW + 1;
	localparam int TW  = $clog2(TASKS);
	localparam int LKW = TW + 1;
	localparam int DW  = (PB > 24) ? PB : 24;
	localparam int EW  = twts_pkg::ECNT_W;
	localparam logic [32:0]    W33   = 33'(W);
	localparam logic [LI-1:0]  OVF_L = LI'(W);
	localparam logic [LKW-1:0] NIL   = {1'b1, {TW{1'b0}}};

	logic [LKW-1:0] head_mem [0:W];
	logic [LKW-1:0] tail_mem [0:W];
	logic [LKW-1:0] next_mem [0:TASKS-1];
	logic [LKW-1:0] prev_mem [0:TASKS-1];
	logic [LI-1:0]  list_mem [0:TASKS-1];
	logic [PB-1:0]  per_mem  [0:TASKS-1];
	logic [PB-1:0]  cnt_mem  [0:TASKS-1];

	logic [LKW-1:0] rd_head_q, rd_tail_q, rd_next_q, rd_prev_q;
	logic [LI-1:0]  rd_list_q;
	logic [PB-1:0]  rd_per_q, rd_cnt_q;

	logic [1:0]     mode_q;
	logic [3:0]     id_q;
	logic [PB-1:0]  per_q;
	logic [23:0]    dly_q;
	logic [SW-1:0]  pos_q;
	logic [TW-1:0]  t_q;
	logic [DW-1:0]  d_q;
	logic [LI-1:0]  l_q;
	logic [LKW-1:0] cur_q, nxt_q;
	logic [PB-1:0]  rev_q;
	logic           ok_q, ovf_q;
	logic [1:0]     place_q [0:TASKS-1];
	logic [LI-1:0]  clr_q;
	logic [EW-1:0]  ecnt_q;
	logic           pend_v_q, out_v_q;
	logic [1:0]     pend_kind_q, out_kind_q;
	logic [3:0]     pend_task_q, out_task_q;
	logic           out_last_q;

	logic           head_we, tail_we, next_we, prev_we, list_we, cnt_we, per_we;
	logic [LI-1:0]  head_wa, tail_wa;
	logic [LKW-1:0] head_wd, tail_wd, next_wd, prev_wd;
	logic [TW-1:0]  next_wa, prev_wa, list_wa, cnt_wa, per_wa;
	logic [LI-1:0]  list_wd;
	logic [PB-1:0]  cnt_wd, per_wd;
	logic           head_re, tail_re, task_re;
	logic [LI-1:0]  head_ra, tail_ra;
	logic [TW-1:0]  task_ra;

	logic           id_ok, bad, placed, out_free, ecnt_room, emit_go, fin_go, out_load;
	logic [TW-1:0]  id_idx, cur_idx;
	logic [PB-1:0]  left, rev_next;
	logic [LI-1:0]  sum, slot, tgt_l;
	logic [SW-1:0]  pos_inc;
	logic [1:0]     emit_kind;
	logic [3:0]     emit_task;

	assign id_ok     = 32'(id_q) < TASKS;
	assign id_idx    = TW'(id_q);
	assign cur_idx   = cur_q[TW-1:0];
	assign bad       = !id_ok || (per_q == '0) ||
	                   ((33'(dly_q) >= W33) && (33'(per_q) < W33));
	assign placed    = place_q[t_q] != twts_pkg::PLACE_IDLE;
	assign left      = rd_per_q - rev_q;
	assign rev_next  = rd_cnt_q + PB'(W);
	assign sum       = {1'b0, pos_q} + {1'b0, d_q[SW-1:0]};
	assign slot      = (sum >= OVF_L) ? sum - OVF_L : sum;
	assign tgt_l     = (33'(d_q) >= W33) ? OVF_L : slot;
	assign pos_inc   = (pos_q == SW'(W - 1)) ? '0 : pos_q + 1'b1;
	assign out_free  = !out_v_q || m_tready;
	assign ecnt_room = ecnt_q < EW'(twts_pkg::MAX_OUT);
	assign emit_go   = !ecnt_room || !pend_v_q || out_free;
	assign fin_go    = !pend_v_q || out_free;
	assign out_load  = pend_v_q && out_free &&
	                   (((cmd.op == twts_pkg::OP_EMIT) && ecnt_room) ||
	                    (cmd.op == twts_pkg::OP_FIN));
	assign emit_kind = (mode_q == twts_pkg::MODE_TICK) ? twts_pkg::KIND_FIRE :
	                   (ok_q ? twts_pkg::KIND_ACC : twts_pkg::KIND_REJ);
	assign emit_task = (mode_q == twts_pkg::MODE_TICK) ? 4'(cur_idx) : id_q;

	assign sts.mode       = mode_q;
	assign sts.bad        = bad;
	assign sts.ovf        = ovf_q;
	assign sts.head_nil   = rd_head_q[TW];
	assign sts.nxt_nil    = nxt_q[TW];
	assign sts.left_zero  = left == '0;
	assign sts.left_small = 33'(left) < W33;
	assign sts.emit_go    = emit_go;
	assign sts.fin_go     = fin_go;
	assign sts.clr_last   = clr_q == OVF_L;
	assign sts.rem_ok     = id_ok && placed;

	assign m_tvalid = out_v_q;
	assign m_tdata  = {2'b00, out_task_q, out_kind_q};
	assign m_tlast  = out_last_q;

	always_comb begin
		head_we = 1'b0; head_wa = '0; head_wd = NIL;
		tail_we = 1'b0; tail_wa = '0; tail_wd = NIL;
		next_we = 1'b0; next_wa = '0; next_wd = NIL;
		prev_we = 1'b0; prev_wa = '0; prev_wd = NIL;
		list_we = 1'b0; list_wa = '0; list_wd = '0;
		cnt_we  = 1'b0; cnt_wa  = '0; cnt_wd  = '0;
		per_we  = 1'b0; per_wa  = '0; per_wd  = '0;
		head_re = 1'b0; head_ra = '0;
		tail_re = 1'b0; tail_ra = '0;
		task_re = 1'b0; task_ra = '0;
		case (cmd.op)
			twts_pkg::OP_CLR: begin
				head_we = 1'b1; head_wa = clr_q;
				tail_we = 1'b1; tail_wa = clr_q;
			end
			twts_pkg::OP_HRD: begin
				head_re = 1'b1;
				head_ra = (pos_q == '0) ? OVF_L : {1'b0, pos_q};
			end
			twts_pkg::OP_SHRD: begin
				head_re = 1'b1;
				head_ra = {1'b0, pos_q};
			end
			twts_pkg::OP_WRD: begin
				task_re = 1'b1;
				task_ra = cur_idx;
			end
			twts_pkg::OP_PRD: begin
				task_re = 1'b1;
				task_ra = t_q;
			end
			twts_pkg::OP_TRD: begin
				tail_re = 1'b1;
				tail_ra = l_q;
			end
			twts_pkg::OP_WDO: begin
				if (ovf_q) begin
					cnt_we = 1'b1; cnt_wa = cur_idx; cnt_wd = rev_next;
				end
			end
			twts_pkg::OP_OEV: begin
				if (left == '0) begin
					cnt_we = 1'b1; cnt_wa = cur_idx; cnt_wd = '0;
				end
			end
			twts_pkg::OP_ADD: begin
				per_we = 1'b1; per_wa = id_idx; per_wd = per_q;
			end
			twts_pkg::OP_PUNL: begin
				if (placed) begin
					if (rd_prev_q[TW]) begin
						head_we = 1'b1; head_wa = rd_list_q; head_wd = rd_next_q;
					end else begin
						next_we = 1'b1; next_wa = rd_prev_q[TW-1:0]; next_wd = rd_next_q;
					end
					if (rd_next_q[TW]) begin
						tail_we = 1'b1; tail_wa = rd_list_q; tail_wd = rd_prev_q;
					end else begin
						prev_we = 1'b1; prev_wa = rd_next_q[TW-1:0]; prev_wd = rd_prev_q;
					end
				end
			end
			twts_pkg::OP_APP1: begin
				prev_we = 1'b1; prev_wa = t_q; prev_wd = rd_tail_q;
				next_we = 1'b1; next_wa = t_q; next_wd = NIL;
				list_we = 1'b1; list_wa = t_q; list_wd = l_q;
				cnt_we  = 1'b1; cnt_wa  = t_q; cnt_wd  = '0;
				tail_we = 1'b1; tail_wa = l_q; tail_wd = {1'b0, t_q};
				if (rd_tail_q[TW]) begin
					head_we = 1'b1; head_wa = l_q; head_wd = {1'b0, t_q};
				end
			end
			twts_pkg::OP_APP2: begin
				if (!rd_tail_q[TW]) begin
					next_we = 1'b1; next_wa = rd_tail_q[TW-1:0]; next_wd = {1'b0, t_q};
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (head_we) head_mem[head_wa] <= head_wd;
		if (head_re) rd_head_q <= head_mem[head_ra];
	end

	always_ff @(posedge clk) begin
		if (tail_we) tail_mem[tail_wa] <= tail_wd;
		if (tail_re) rd_tail_q <= tail_mem[tail_ra];
	end

	always_ff @(posedge clk) begin
		if (next_we) next_mem[next_wa] <= next_wd;
		if (task_re) rd_next_q <= next_mem[task_ra];
	end

	always_ff @(posedge clk) begin
		if (prev_we) prev_mem[prev_wa] <= prev_wd;
		if (task_re) rd_prev_q <= prev_mem[task_ra];
	end

	always_ff @(posedge clk) begin
		if (list_we) list_mem[list_wa] <= list_wd;
		if (task_re) rd_list_q <= list_mem[task_ra];
	end

	always_ff @(posedge clk) begin
		if (per_we) per_mem[per_wa] <= per_wd;
		if (task_re) rd_per_q <= per_mem[task_ra];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
		if (task_re) rd_cnt_q <= cnt_mem[task_ra];
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			twts_pkg::OP_IDLE: begin
				mode_q <= s_tdata[1:0];
				id_q   <= s_tdata[5:2];
				per_q  <= PB'(s_tdata[29:6]);
				dly_q  <= s_tdata[53:30];
			end
			twts_pkg::OP_DEC: begin
				t_q  <= id_idx;
				ok_q <= (mode_q == twts_pkg::MODE_ADD) && !bad;
			end
			twts_pkg::OP_RCHK: ok_q <= id_ok && placed;
			twts_pkg::OP_ADD:  d_q <= DW'(dly_q);
			twts_pkg::OP_HGOT: cur_q <= rd_head_q;
			twts_pkg::OP_WDO: begin
				nxt_q <= rd_next_q;
				rev_q <= rev_next;
				t_q   <= cur_idx;
				d_q   <= DW'(rd_per_q);
			end
			twts_pkg::OP_OEV: begin
				t_q <= cur_idx;
				d_q <= DW'(left);
			end
			twts_pkg::OP_NX:   cur_q <= nxt_q;
			twts_pkg::OP_PUNL: l_q <= tgt_l;
			default: begin
			end
		endcase
		if (out_load) begin
			out_kind_q <= pend_kind_q;
			out_task_q <= pend_task_q;
			out_last_q <= (cmd.op == twts_pkg::OP_FIN);
		end
		if ((cmd.op == twts_pkg::OP_EMIT) && ecnt_room && (!pend_v_q || out_free)) begin
			pend_kind_q <= emit_kind;
			pend_task_q <= emit_task;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			clr_q    <= '0;
			ecnt_q   <= '0;
			ovf_q    <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			for (int i = 0; i < TASKS; i++) place_q[i] <= twts_pkg::PLACE_IDLE;
		end else begin
			if (out_load) out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;
			case (cmd.op)
				twts_pkg::OP_CLR:  clr_q <= clr_q + 1'b1;
				twts_pkg::OP_IDLE: ecnt_q <= '0;
				twts_pkg::OP_TICK: pos_q <= pos_inc;
				twts_pkg::OP_HRD:  ovf_q <= (pos_q == '0);
				twts_pkg::OP_SHRD: ovf_q <= 1'b0;
				twts_pkg::OP_PUNL: place_q[t_q] <= twts_pkg::PLACE_IDLE;
				twts_pkg::OP_APP1: begin
					place_q[t_q] <= (l_q == OVF_L) ? twts_pkg::PLACE_OVF : twts_pkg::PLACE_SLOT;
				end
				twts_pkg::OP_EMIT: begin
					if (ecnt_room && (!pend_v_q || out_free)) begin
						ecnt_q   <= ecnt_q + 1'b1;
						pend_v_q <= 1'b1;
					end
				end
				twts_pkg::OP_FIN: begin
					if (pend_v_q && out_free) pend_v_q <= 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

### design/twts_chk.sv
// ----------------------------------------------------------------------------
// twts_chk
// Port-level checks on the scheduler's streams.
// ----------------------------------------------------------------------------
module twts_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [55:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item taken during work");

	a_answer_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[1:0] != twts_pkg::KIND_FIRE) |-> m_tlast)
		else $error("request answer not marked last");

endmodule

bind timing_wheel_task_scheduler_unit twts_chk u_twts_chk (.*);
